### design/irpd_pkg.sv
// Shared types and constants for the pulse-distance infrared decoder.
// Used by irpd_regs, irpd_window, irpd_fsm and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package irpd_pkg;

  // Frame geometry
  localparam int ADDR_WIDTH  = 16;
  localparam int CMD_BITS    = 8;
  localparam int ADDR_OUT_W  = 16;
  localparam int CMD_OUT_W   = 8;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CNT_W       = 5;
  localparam int CFG_IDX_W   = 3;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_PULSE  = 3'd0,
    REG_START_PERIOD = 3'd1,
    REG_DATA_PULSE   = 3'd2,
    REG_ZERO_PERIOD  = 3'd3,
    REG_ONE_PERIOD   = 3'd4,
    REG_STOP_PULSE   = 3'd5,
    REG_TOLERANCE    = 3'd6,
    REG_ADDRESS_BITS = 3'd7
  } reg_index_t;

  // Reset values of the timing registers
  localparam logic [CFG_W-1:0] RST_START_PULSE  = 16'd9000;
  localparam logic [CFG_W-1:0] RST_START_PERIOD = 16'd13500;
  localparam logic [CFG_W-1:0] RST_DATA_PULSE   = 16'd562;
  localparam logic [CFG_W-1:0] RST_ZERO_PERIOD  = 16'd1125;
  localparam logic [CFG_W-1:0] RST_ONE_PERIOD   = 16'd2250;
  localparam logic [CFG_W-1:0] RST_STOP_PULSE   = 16'd562;
  localparam logic [CFG_W-1:0] RST_TOLERANCE    = 16'd200;
  localparam logic [CNT_W-1:0] RST_ADDRESS_BITS = 5'd8;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_HIGH  = 2'd2,
    ST_LONG  = 2'd3
  } status_t;

  // Decoder phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_START = 5'b00010,
    PH_ADDR  = 5'b00100,
    PH_CMD   = 5'b01000,
    PH_STOP  = 5'b10000
  } phase_t;

  // Configuration register bank
  typedef struct packed {
    logic [CFG_W-1:0] start_pulse_us;
    logic [CFG_W-1:0] start_period_us;
    logic [CFG_W-1:0] data_pulse_us;
    logic [CFG_W-1:0] zero_period_us;
    logic [CFG_W-1:0] one_period_us;
    logic [CFG_W-1:0] stop_pulse_us;
    logic [CFG_W-1:0] tolerance_us;
    logic [CNT_W-1:0] address_bits;
  } cfg_t;

  // Position of the elapsed time against one window
  typedef struct packed {
    logic below_lo;
    logic below_hi;
  } win_t;

  // One result beat
  typedef struct packed {
    status_t               status;
    logic                  frame_done;
    logic [ADDR_OUT_W-1:0] address_out;
    logic [CMD_OUT_W-1:0]  command_out;
  } result_t;

endpackage

`default_nettype wire

### design/irpd_regs.sv
// Configuration register bank of the infrared decoder.
// Depends on irpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irpd_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [irpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [irpd_pkg::CFG_W-1:0]     cfg_data,
  output irpd_pkg::cfg_t                     cfg
);
  import irpd_pkg::*;

  // Register writes, one per cycle, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_pulse_us  <= RST_START_PULSE;
      cfg.start_period_us <= RST_START_PERIOD;
      cfg.data_pulse_us   <= RST_DATA_PULSE;
      cfg.zero_period_us  <= RST_ZERO_PERIOD;
      cfg.one_period_us   <= RST_ONE_PERIOD;
      cfg.stop_pulse_us   <= RST_STOP_PULSE;
      cfg.tolerance_us    <= RST_TOLERANCE;
      cfg.address_bits    <= RST_ADDRESS_BITS;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_START_PULSE:  cfg.start_pulse_us  <= cfg_data;
        REG_START_PERIOD: cfg.start_period_us <= cfg_data;
        REG_DATA_PULSE:   cfg.data_pulse_us   <= cfg_data;
        REG_ZERO_PERIOD:  cfg.zero_period_us  <= cfg_data;
        REG_ONE_PERIOD:   cfg.one_period_us   <= cfg_data;
        REG_STOP_PULSE:   cfg.stop_pulse_us   <= cfg_data;
        REG_TOLERANCE:    cfg.tolerance_us    <= cfg_data;
        REG_ADDRESS_BITS: cfg.address_bits    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/irpd_window.sv
// Timing window test: elapsed time against [nominal - tol, nominal + tol).
// Lower bound saturates at zero. Depends on irpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irpd_window (
  input  wire logic [irpd_pkg::TIME_W-1:0] elapsed,
  input  wire logic [irpd_pkg::CFG_W-1:0]  nominal,
  input  wire logic [irpd_pkg::CFG_W-1:0]  tolerance,
  output irpd_pkg::win_t                  win
);
  import irpd_pkg::*;

  logic [CFG_W-1:0] lo;
  logic [CFG_W:0]   hi;

  // Bounds
  assign lo = (nominal > tolerance) ? (nominal - tolerance) : '0;
  assign hi = {1'b0, nominal} + {1'b0, tolerance};

  // Upper bound itself counts as beyond the window
  assign win.below_lo = elapsed < {{(TIME_W-CFG_W){1'b0}}, lo};
  assign win.below_hi = elapsed < {{(TIME_W-CFG_W-1){1'b0}}, hi};

endmodule

`default_nettype wire

### design/irpd_fsm.sv
// Frame state machine and bit collection of the infrared decoder.
// Holds phase, bit count, symbol start time and the shift registers.
// Depends on irpd_pkg and irpd_window.
`timescale 1ns / 1ps
`default_nettype none

module irpd_fsm (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic                        func,
  input  wire logic                        line_level,
  input  wire logic [irpd_pkg::TIME_W-1:0] time_us,
  input  wire irpd_pkg::cfg_t              cfg,
  output irpd_pkg::result_t                result
);
  import irpd_pkg::*;

  localparam logic [CNT_W-1:0] CMD_LAST = CNT_W'(CMD_BITS);

  phase_t                 phase, phase_next;
  logic [CNT_W-1:0]       bit_counter, bit_counter_next;
  logic [TIME_W-1:0]      symbol_start_time, symbol_start_time_next;
  logic [ADDR_WIDTH-1:0]  address_shift, address_shift_next;
  logic [CMD_BITS-1:0]    command_shift, command_shift_next;

  logic [TIME_W-1:0] elapsed;
  logic [CFG_W-1:0]  nom0, nom1, nom2, short_p, long_p;
  logic              short_v;
  win_t              w0, w1, w2;
  logic              sym_done, sym_bit;
  logic [CNT_W-1:0]  cnt_inc;
  status_t           status;
  logic              frame_done;

  assign elapsed = time_us - symbol_start_time;

  // The shorter period decodes as its own bit value; ties go to the one-symbol
  always_comb begin
    if (cfg.zero_period_us < cfg.one_period_us) begin
      short_p = cfg.zero_period_us;
      long_p  = cfg.one_period_us;
      short_v = 1'b0;
    end else begin
      short_p = cfg.one_period_us;
      long_p  = cfg.zero_period_us;
      short_v = 1'b1;
    end
  end

  // Window nominals chosen by phase: pulse, first period, second period
  always_comb begin
    case (phase)
      PH_START: begin
        nom0 = cfg.start_pulse_us;
        nom1 = cfg.start_period_us;
      end
      PH_STOP: begin
        nom0 = cfg.stop_pulse_us;
        nom1 = short_p;
      end
      default: begin
        nom0 = cfg.data_pulse_us;
        nom1 = short_p;
      end
    endcase
    nom2 = long_p;
  end

  irpd_window u_win0 (.elapsed(elapsed), .nominal(nom0), .tolerance(cfg.tolerance_us), .win(w0));
  irpd_window u_win1 (.elapsed(elapsed), .nominal(nom1), .tolerance(cfg.tolerance_us), .win(w1));
  irpd_window u_win2 (.elapsed(elapsed), .nominal(nom2), .tolerance(cfg.tolerance_us), .win(w2));

  assign cnt_inc = bit_counter + CNT_W'(1);

  // Next state and status for one sample
  always_comb begin
    phase_next             = phase;
    bit_counter_next       = bit_counter;
    symbol_start_time_next = symbol_start_time;
    address_shift_next     = address_shift;
    command_shift_next     = command_shift;
    status                 = ST_OK;
    frame_done             = 1'b0;
    sym_done               = 1'b0;
    sym_bit                = 1'b0;

    if (func) begin
      // restart
      phase_next             = PH_IDLE;
      bit_counter_next       = '0;
      symbol_start_time_next = '0;
      address_shift_next     = '0;
      command_shift_next     = '0;
    end else begin
      case (phase)
        PH_START: begin
          if (w0.below_lo) begin
            if (!line_level) status = ST_SHORT;
          end else if (w0.below_hi) begin
          end else if (w1.below_lo) begin
            if (line_level) status = ST_HIGH;
          end else if (w1.below_hi) begin
            if (line_level) begin
              symbol_start_time_next = time_us;
              phase_next             = PH_ADDR;
            end
          end else begin
            status = ST_LONG;
          end
        end

        PH_ADDR, PH_CMD: begin
          // data symbol classification
          if (w0.below_lo) begin
            if (!line_level) status = ST_SHORT;
          end else if (w0.below_hi) begin
          end else if (w1.below_lo) begin
            if (line_level) status = ST_HIGH;
          end else if (w1.below_hi) begin
            sym_done = line_level;
            sym_bit  = short_v;
          end else if (w2.below_lo) begin
            if (line_level) status = ST_HIGH;
          end else if (w2.below_hi) begin
            sym_done = line_level;
            sym_bit  = ~short_v;
          end else begin
            status = ST_LONG;
          end

          // bit store, least significant first
          if (sym_done) begin
            if (phase == PH_ADDR) begin
              for (int i = 0; i < ADDR_WIDTH; i++) begin
                if (bit_counter == CNT_W'(i)) address_shift_next[i] = sym_bit;
              end
            end else begin
              for (int i = 0; i < CMD_BITS; i++) begin
                if (bit_counter == CNT_W'(i)) command_shift_next[i] = sym_bit;
              end
            end
            bit_counter_next       = cnt_inc;
            symbol_start_time_next = time_us;
            if (phase == PH_ADDR && cnt_inc == cfg.address_bits) begin
              phase_next       = PH_CMD;
              bit_counter_next = '0;
            end else if (phase == PH_CMD && cnt_inc == CMD_LAST) begin
              phase_next       = PH_STOP;
              bit_counter_next = '0;
            end
          end
        end

        PH_STOP: begin
          if (w0.below_lo) begin
            if (!line_level) status = ST_SHORT;
          end else if (w0.below_hi) begin
            if (!line_level) begin
              frame_done = 1'b1;
              phase_next = PH_IDLE;
            end
          end else begin
            if (line_level) status = ST_HIGH;
          end
        end

        default: begin
          // idle: a high level opens a frame
          phase_next = PH_IDLE;
          if (line_level) begin
            phase_next             = PH_START;
            symbol_start_time_next = time_us;
          end
        end
      endcase
    end
  end

  // State update on each processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      bit_counter       <= '0;
      symbol_start_time <= '0;
      address_shift     <= '0;
      command_shift     <= '0;
    end else if (step) begin
      phase             <= phase_next;
      bit_counter       <= bit_counter_next;
      symbol_start_time <= symbol_start_time_next;
      address_shift     <= address_shift_next;
      command_shift     <= command_shift_next;
    end
  end

  // Result fields show the shift registers after this sample
  assign result.status      = status;
  assign result.frame_done  = frame_done;
  assign result.address_out = ADDR_OUT_W'(address_shift_next);
  assign result.command_out = CMD_OUT_W'(command_shift_next);

endmodule

`default_nettype wire

### design/ir_pulse_distance_decoder.sv
// Top level of the pulse-distance (NEC style) infrared frame decoder.
// Depends on irpd_pkg, irpd_regs, irpd_window and irpd_fsm.
//
//  Channel  Direction  Beat contents
//  s_*      in         tuser: func; tdata: line_level, time_us[31:0], pad
//  m_*      out        tlast: frame_done; tdata: status, address_out, command_out, pad
//  cfg_*    in         write enable, register index 0..7, 16-bit data
//
// One beat per cycle in unless m_tready stalls, one result beat per input beat out.
// The path runs through the input register, then the decode logic into the result register.
// The single decode pass sets the sustained rate, one sample per clock unless m_tready stalls.
// A stall on m_tready holds the result; an empty input register still takes one more beat.
// rst is synchronous; it returns the registers and the decoder state to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_distance_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // input samples
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [39:0] s_tdata,   // [0] line_level, [32:1] time_us, [39:33] zero
  input  wire logic        s_tuser,   // [0] func
  // results
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [31:0] m_tdata,   // [1:0] status, [17:2] address_out,
                                      // [25:18] command_out, [31:26] zero
  output      logic        m_tlast,   // frame_done
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import irpd_pkg::*;

  cfg_t              cfg;
  result_t           result;
  result_t           out_q;
  logic              in_valid;
  logic              in_func;
  logic              in_level;
  logic [TIME_W-1:0] in_time;
  logic              advance;
  logic              step;

  irpd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Pipeline control
  assign advance  = ~m_tvalid | m_tready;
  assign step     = in_valid & advance;
  assign s_tready = ~in_valid | advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func  <= s_tuser;
      in_level <= s_tdata[0];
      in_time  <= s_tdata[TIME_W:1];
    end
  end

  irpd_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .func       (in_func),
    .line_level (in_level),
    .time_us    (in_time),
    .cfg        (cfg),
    .result     (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign m_tlast = out_q.frame_done;
  assign m_tdata = {6'd0, out_q.command_out, out_q.address_out, out_q.status};

  // A finished frame always carries an ok status
  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[1:0] == ST_OK))
    else $error("frame_done with non-ok status");

  // A processed sample always lands in the result register
  a_step_out: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("processed beat lost");

  // A restart gives an all-zero result
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (step && in_func) |=> (m_tdata == 32'd0 && !m_tlast))
    else $error("restart result not cleared");

  // An empty input register never refuses a beat
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stalled while empty");

endmodule

`default_nettype wire

### sim/irpd_tb_pkg.sv
// Testbench-side codes for the pulse-distance infrared decoder.
// Shared by irpd_result_check and tb_ir_pulse_distance_decoder; no dependencies.
`timescale 1ns / 1ps

package irpd_tb_pkg;

  // Item kinds carried on s_tuser
  localparam logic FN_SAMPLE  = 1'b0;
  localparam logic FN_RESTART = 1'b1;

endpackage

### sim/irpd_result_check.sv
// Result checker for the pulse-distance infrared decoder: tracks register writes,
// decodes every accepted sample and compares the result beats in order.
// Depends on irpd_pkg and irpd_tb_pkg.
`timescale 1ns / 1ps

module irpd_result_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // [0] line_level, [32:1] time_us, [39:33] zero
  input  logic        s_tuser,   // [0] func
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [1:0] status, [17:2] address_out, [25:18] command_out
  input  logic        m_tlast,   // frame_done
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          outstanding,
  output int          beats_checked,
  output int          frames_done
);
  import irpd_pkg::*;
  import irpd_tb_pkg::*;

  // Own copy of the registers and of the decoder state
  cfg_t        cfg;
  phase_t      phase;
  logic [4:0]  bit_cnt;
  logic [31:0] sym_start;
  logic [15:0] addr_sh;
  logic [7:0]  cmd_sh;

  result_t pending_results[$];

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR at %0t ns, result %0d: %s is 0x%0h, expected 0x%0h",
             $time, beats_checked, what, got, want);
    errors++;
  endtask

  // Window edges; the lower one saturates at zero
  function automatic logic [31:0] lo_edge(logic [15:0] nom);
    return (nom > cfg.tolerance_us) ? 32'(nom - cfg.tolerance_us) : 32'd0;
  endfunction

  function automatic logic [31:0] hi_edge(logic [15:0] nom);
    return 32'(nom) + 32'(cfg.tolerance_us);
  endfunction

  // Classify elapsed time within a data symbol
  function automatic status_t data_symbol(input logic [31:0] el, input logic high,
                                          output logic done, output logic bitv);
    logic [15:0] short_p, long_p;
    logic        short_v;
    done = 1'b0;
    bitv = 1'b0;
    // equal periods: the one-symbol counts as the shorter
    if (cfg.zero_period_us < cfg.one_period_us) begin
      short_p = cfg.zero_period_us;
      long_p  = cfg.one_period_us;
      short_v = 1'b0;
    end else begin
      short_p = cfg.one_period_us;
      long_p  = cfg.zero_period_us;
      short_v = 1'b1;
    end
    if (el < lo_edge(cfg.data_pulse_us)) begin
      if (!high) return ST_SHORT;
    end else if (el < hi_edge(cfg.data_pulse_us)) begin
    end else if (el < lo_edge(short_p)) begin
      if (high) return ST_HIGH;
    end else if (el < hi_edge(short_p)) begin
      if (high) begin
        done = 1'b1;
        bitv = short_v;
      end
    end else if (el < lo_edge(long_p)) begin
      if (high) return ST_HIGH;
    end else if (el < hi_edge(long_p)) begin
      if (high) begin
        done = 1'b1;
        bitv = !short_v;
      end
    end else begin
      return ST_LONG;
    end
    return ST_OK;
  endfunction

  // Decode one item and advance the state; errors leave the state alone
  function automatic result_t decode_sample(logic fn, logic high, logic [31:0] now);
    result_t     r;
    logic [31:0] el;
    logic        done, bitv;
    status_t     st;
    logic        fin;
    el  = now - sym_start;
    st  = ST_OK;
    fin = 1'b0;
    if (fn == FN_RESTART) begin
      phase     = PH_IDLE;
      bit_cnt   = '0;
      sym_start = '0;
      addr_sh   = '0;
      cmd_sh    = '0;
    end else begin
      case (phase)
        PH_START: begin
          if (el < lo_edge(cfg.start_pulse_us)) begin
            if (!high) st = ST_SHORT;
          end else if (el < hi_edge(cfg.start_pulse_us)) begin
          end else if (el < lo_edge(cfg.start_period_us)) begin
            if (high) st = ST_HIGH;
          end else if (el < hi_edge(cfg.start_period_us)) begin
            if (high) begin
              sym_start = now;
              phase     = PH_ADDR;
            end
          end else begin
            st = ST_LONG;
          end
        end
        PH_ADDR, PH_CMD: begin
          st = data_symbol(el, high, done, bitv);
          if (st == ST_OK && done) begin
            // bits past the register width are dropped
            if (phase == PH_ADDR) begin
              if (bit_cnt < ADDR_WIDTH) addr_sh[bit_cnt[3:0]] = bitv;
            end else begin
              if (bit_cnt < CMD_BITS) cmd_sh[bit_cnt[2:0]] = bitv;
            end
            bit_cnt = bit_cnt + 5'd1;
            if (phase == PH_ADDR && bit_cnt == cfg.address_bits) begin
              phase   = PH_CMD;
              bit_cnt = '0;
            end else if (phase == PH_CMD && bit_cnt == 5'(CMD_BITS)) begin
              phase   = PH_STOP;
              bit_cnt = '0;
            end
            sym_start = now;
          end
        end
        PH_STOP: begin
          if (el < lo_edge(cfg.stop_pulse_us)) begin
            if (!high) st = ST_SHORT;
          end else if (el < hi_edge(cfg.stop_pulse_us)) begin
            if (!high) begin
              fin   = 1'b1;
              phase = PH_IDLE;
            end
          end else begin
            // late low just waits
            if (high) st = ST_HIGH;
          end
        end
        default: begin
          phase = PH_IDLE;
          if (high) begin
            phase     = PH_START;
            sym_start = now;
          end
        end
      endcase
    end
    r.status      = st;
    r.frame_done  = fin;
    r.address_out = addr_sh;
    r.command_out = cmd_sh;
    return r;
  endfunction

  // Watch all three channels at each rising edge
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      cfg.start_pulse_us  = RST_START_PULSE;
      cfg.start_period_us = RST_START_PERIOD;
      cfg.data_pulse_us   = RST_DATA_PULSE;
      cfg.zero_period_us  = RST_ZERO_PERIOD;
      cfg.one_period_us   = RST_ONE_PERIOD;
      cfg.stop_pulse_us   = RST_STOP_PULSE;
      cfg.tolerance_us    = RST_TOLERANCE;
      cfg.address_bits    = RST_ADDRESS_BITS;
      phase               = PH_IDLE;
      bit_cnt             = '0;
      sym_start           = '0;
      addr_sh             = '0;
      cmd_sh              = '0;
      pending_results.delete();
      errors              = 0;
      beats_checked       = 0;
      frames_done         = 0;
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_START_PULSE:  cfg.start_pulse_us  = cfg_data;
          REG_START_PERIOD: cfg.start_period_us = cfg_data;
          REG_DATA_PULSE:   cfg.data_pulse_us   = cfg_data;
          REG_ZERO_PERIOD:  cfg.zero_period_us  = cfg_data;
          REG_ONE_PERIOD:   cfg.one_period_us   = cfg_data;
          REG_STOP_PULSE:   cfg.stop_pulse_us   = cfg_data;
          REG_TOLERANCE:    cfg.tolerance_us    = cfg_data;
          REG_ADDRESS_BITS: cfg.address_bits    = cfg_data[4:0];
          default: ;
        endcase
      end
      // result beat against the oldest expectation
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report("result beat with nothing pending", m_tdata, '0);
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[1:0] != want.status)
            report("status", m_tdata[1:0], want.status);
          if (m_tlast != want.frame_done)
            report("frame_done", m_tlast, want.frame_done);
          if (m_tdata[17:2] != want.address_out)
            report("address_out", m_tdata[17:2], want.address_out);
          if (m_tdata[25:18] != want.command_out)
            report("command_out", m_tdata[25:18], want.command_out);
          if (want.frame_done) frames_done++;
          beats_checked++;
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(decode_sample(s_tuser, s_tdata[0], s_tdata[32:1]));
    end
    outstanding = pending_results.size();
  end

endmodule

### sim/tb_ir_pulse_distance_decoder.sv
// Top of the testbench for ir_pulse_distance_decoder: clock, reset, sample and
// register stimulus, receiver stalls and the verdict. Checking sits in irpd_result_check.
// Depends on irpd_pkg, irpd_tb_pkg, irpd_result_check and the decoder RTL.
`timescale 1ns / 1ps

module tb_ir_pulse_distance_decoder;
  import irpd_pkg::*;
  import irpd_tb_pkg::*;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata   = '0;
  logic        s_tuser   = FN_SAMPLE;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = REG_START_PULSE;
  logic [15:0] cfg_data  = '0;

  int errors, outstanding, beats_checked, frames_done;
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int samples_sent   = 0;
  int settings_used  = 0;
  logic [31:0] t_base = '0;
  cfg_t cur_cfg;

  always #2 clk = ~clk;

  ir_pulse_distance_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  irpd_result_check u_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .outstanding   (outstanding),
    .beats_checked (beats_checked),
    .frames_done   (frames_done)
  );

  // Receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // One sample beat; valid stays up after the handshake so beats can run back to back
  task automatic send_item(logic fn, logic high, logic [31:0] t);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {7'd0, t, high};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    samples_sent++;
  endtask

  // Wait until every result is back, then let the pipeline settle
  task automatic drain();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    do begin
      @(negedge clk);
      guard++;
    end while (outstanding != 0 && guard < 200000);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic write_cfg(cfg_t c);
    drain();
    write_reg(REG_START_PULSE,  c.start_pulse_us);
    write_reg(REG_START_PERIOD, c.start_period_us);
    write_reg(REG_DATA_PULSE,   c.data_pulse_us);
    write_reg(REG_ZERO_PERIOD,  c.zero_period_us);
    write_reg(REG_ONE_PERIOD,   c.one_period_us);
    write_reg(REG_STOP_PULSE,   c.stop_pulse_us);
    write_reg(REG_TOLERANCE,    c.tolerance_us);
    // upper bits of the count register are junk
    write_reg(REG_ADDRESS_BITS, {11'($urandom), c.address_bits});
    cfg_we  <= 1'b0;
    cur_cfg  = c;
    settings_used++;
  endtask

  // Timing choices for well-formed symbols
  function automatic logic [31:0] window_lo(logic [15:0] nom);
    return (nom > cur_cfg.tolerance_us) ? 32'(nom - cur_cfg.tolerance_us) : 32'd0;
  endfunction

  function automatic logic [31:0] window_hi(logic [15:0] nom);
    return 32'(nom) + 32'(cur_cfg.tolerance_us);
  endfunction

  function automatic logic [31:0] in_window(logic [15:0] nom);
    logic [31:0] lo, hi;
    lo = window_lo(nom);
    hi = window_hi(nom);
    case ($urandom_range(15, 0))
      0:       return hi;   // exactly on the upper edge, counts as outside
      1:       return lo;
      default: return (hi > lo) ? lo + $urandom_range(hi - lo - 1, 0) : lo;
    endcase
  endfunction

  function automatic logic [31:0] below_window(logic [15:0] nom);
    logic [31:0] lo;
    lo = window_lo(nom);
    return (lo == 0) ? 32'd0 : $urandom_range(lo - 1, 0);
  endfunction

  // Occasional stray beat inside a frame
  task automatic maybe_noise(logic [31:0] t);
    if ($urandom_range(24, 0) == 0)
      send_item(($urandom_range(3, 0) == 0) ? FN_RESTART : FN_SAMPLE,
                1'($urandom_range(1, 0)), t + $urandom_range(70000, 0));
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(6, 1))
      send_item(($urandom_range(7, 0) == 0) ? FN_RESTART : FN_SAMPLE,
                1'($urandom_range(1, 0)),
                ($urandom_range(3, 0) == 0) ? $urandom() : t_base + $urandom_range(70000, 0));
  endtask

  // A frame shaped after the current settings, random bits and optional extra samples
  task automatic send_frame();
    logic [31:0] t, late;
    int          nbits;
    logic        bitv;
    if ($urandom_range(4, 0) == 0) t_base = $urandom();
    else t_base = t_base + $urandom_range(20000, 100);
    t = t_base;
    if ($urandom_range(1, 0)) send_item(FN_SAMPLE, 1'b0, t - 32'd50);
    send_item(FN_SAMPLE, 1'b1, t);
    if ($urandom_range(1, 0))
      send_item(FN_SAMPLE, 1'b1, t + below_window(cur_cfg.start_pulse_us));
    if ($urandom_range(1, 0))
      send_item(FN_SAMPLE, 1'b0, t + in_window(cur_cfg.start_pulse_us));
    maybe_noise(t);
    t = t + in_window(cur_cfg.start_period_us);
    send_item(FN_SAMPLE, 1'b1, t);
    // zero in the count register means 32 address bits
    nbits = (cur_cfg.address_bits == 0) ? 32 : cur_cfg.address_bits;
    nbits = nbits + CMD_BITS;
    for (int i = 0; i < nbits; i++) begin
      if ($urandom_range(3, 0) == 0)
        send_item(FN_SAMPLE, 1'b1, t + below_window(cur_cfg.data_pulse_us));
      if ($urandom_range(1, 0))
        send_item(FN_SAMPLE, 1'b0, t + in_window(cur_cfg.data_pulse_us));
      maybe_noise(t);
      bitv = 1'($urandom_range(1, 0));
      t = t + in_window(bitv ? cur_cfg.one_period_us : cur_cfg.zero_period_us);
      send_item(FN_SAMPLE, 1'b1, t);
    end
    if ($urandom_range(3, 0) == 0)
      send_item(FN_SAMPLE, 1'b1, t + below_window(cur_cfg.stop_pulse_us));
    if ($urandom_range(7, 0) == 0) begin
      // stop pulse too late: low waits, then a high is flagged
      late = t + window_hi(cur_cfg.stop_pulse_us) + $urandom_range(300, 0);
      send_item(FN_SAMPLE, 1'b0, late);
      send_item(FN_SAMPLE, 1'b1, late + 32'd10);
      send_item(FN_RESTART, 1'($urandom_range(1, 0)), $urandom());
    end else begin
      send_item(FN_SAMPLE, 1'b0, t + in_window(cur_cfg.stop_pulse_us));
    end
    t_base = t;
  endtask

  // Directed opening at reset settings; the frame crosses the timestamp wrap
  task automatic directed_items();
    logic [31:0] t0, t1, t2, t3;
    t0 = 32'hFFFF_E000;
    send_item(FN_RESTART, 1'b1, 32'hFFFF_FFFF);
    send_item(FN_SAMPLE,  1'b0, 32'h0000_1234);
    send_item(FN_SAMPLE,  1'b1, t0);                 // start
    send_item(FN_SAMPLE,  1'b1, t0 + 32'd100);       // still in the pulse
    send_item(FN_SAMPLE,  1'b0, t0 + 32'd5000);      // pulse too short
    send_item(FN_SAMPLE,  1'b0, t0 + 32'd9000);
    send_item(FN_SAMPLE,  1'b1, t0 + 32'd10000);     // high in the gap
    send_item(FN_SAMPLE,  1'b1, t0 + 32'd13700);     // upper edge, too long
    t1 = t0 + 32'd13300;                             // lower edge of the period
    send_item(FN_SAMPLE,  1'b1, t1);
    send_item(FN_SAMPLE,  1'b0, t1 + 32'd100);
    send_item(FN_SAMPLE,  1'b1, t1 + 32'd800);
    send_item(FN_SAMPLE,  1'b0, t1 + 32'd800);
    send_item(FN_SAMPLE,  1'b1, t1 + 32'd1325);      // zero window upper edge
    t2 = t1 + 32'd925;
    send_item(FN_SAMPLE,  1'b1, t2);                 // bit 0
    t3 = t2 + 32'd2449;
    send_item(FN_SAMPLE,  1'b1, t3);                 // bit 1
    send_item(FN_SAMPLE,  1'b1, t3 + 32'd2450);      // too long
    send_item(FN_SAMPLE,  1'b1, t3 + 32'd2050);      // bit 1 at the lower edge
    send_item(FN_RESTART, 1'b0, 32'h8000_0001);      // restart mid-frame
    send_item(FN_SAMPLE,  1'b0, 32'h7FFF_FFFE);
  endtask

  function automatic cfg_t setting(int k);
    cfg_t c;
    case (k)
      0: c = '{RST_START_PULSE, RST_START_PERIOD, RST_DATA_PULSE, RST_ZERO_PERIOD,
               RST_ONE_PERIOD, RST_STOP_PULSE, RST_TOLERANCE, RST_ADDRESS_BITS};
      1: c = '{16'd40, 16'd60, 16'd5, 16'd12, 16'd20, 16'd6, 16'd2, 5'd3};
      // zero symbol longer than one symbol, address longer than the register
      2: c = '{16'd3000, 16'd4500, 16'd300, 16'd1800, 16'd700, 16'd400, 16'd100, 5'd20};
      // equal periods, start pulse window clipped at zero, 32 address bits
      3: c = '{16'd0, 16'hFFFF, 16'd200, 16'd900, 16'd900, 16'hFFFF, 16'd150, 5'd0};
      // no tolerance: every window is empty
      4: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 5'd31};
      5: c = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'hFFFF, 5'd1};
      default: begin
        c.data_pulse_us   = 16'($urandom_range(800, 1));
        c.zero_period_us  = c.data_pulse_us + 16'($urandom_range(3000, 100));
        c.one_period_us   = c.data_pulse_us + 16'($urandom_range(3000, 100));
        c.start_pulse_us  = 16'($urandom_range(20000, 0));
        c.start_period_us = c.start_pulse_us + 16'($urandom_range(20000, 100));
        c.stop_pulse_us   = 16'($urandom_range(2000, 0));
        c.tolerance_us    = 16'($urandom_range(150, 0));
        c.address_bits    = 5'($urandom_range(31, 0));
      end
    endcase
    return c;
  endfunction

  // Stimulus and verdict
  initial begin
    int quota[8];
    int goal;
    quota = '{300, 250, 250, 250, 60, 60, 150, 150};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    cur_cfg = setting(0);
    directed_items();
    for (int k = 0; k < 8; k++) begin
      write_cfg(setting(k));
      case (k % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      goal = samples_sent + quota[k];
      while (samples_sent < goal) begin
        if ($urandom_range(4, 0) != 0) send_frame();
        else noise_burst();
      end
    end
    drain();
    if (outstanding != 0)
      $display("ERROR: %0d results never arrived", outstanding);
    $display("Drove %0d sample beats under %0d register settings and four idle patterns.",
             samples_sent, settings_used);
    $display("Compared %0d result beats, %0d of them closing a frame.",
             beats_checked, frames_done);
    if (errors == 0 && outstanding == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("ERROR: run timed out");
    $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
design/irpd_pkg.sv
design/irpd_regs.sv
design/irpd_window.sv
design/irpd_fsm.sv
design/ir_pulse_distance_decoder.sv
sim/irpd_tb_pkg.sv
sim/irpd_result_check.sv
sim/tb_ir_pulse_distance_decoder.sv
